// ===== rtl/dae_pkg.sv =====
package dae_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = CFG_IDX_W'(1);

  localparam logic [16:0] GAIN_RESET     = 17'd4096;
  localparam logic [16:0] GAIN_FULL      = 17'd65536;
  localparam logic [15:0] SEG_SIZE_RESET = 16'd536;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_BYTES,
    MUL_P1,
    MUL_P2,
    MUL_RED
  } dae_mul_op_t;

  typedef struct packed {
    logic        load;
    logic        mul_en;
    dae_mul_op_t mul_op;
    logic        accum;
    logic        div_init;
    logic        div_step;
    logic        prod_save;
    logic        alpha_wr;
    logic        result_wr;
  } dae_cmd_t;

  typedef struct packed {
    logic window_done;
  } dae_sts_t;

endpackage

// ===== rtl/dae_if.sv =====
interface dae_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] segments_acked;
  logic        ece_flag;
  logic [31:0] high_tx_mark;
  logic [31:0] ack_number;
  logic [31:0] current_cwnd;
  logic [31:0] bytes_in_flight;

  modport source (
    output valid, segments_acked, ece_flag, high_tx_mark, ack_number,
           current_cwnd, bytes_in_flight,
    input  ready
  );
  modport sink (
    input  valid, segments_acked, ece_flag, high_tx_mark, ack_number,
           current_cwnd, bytes_in_flight,
    output ready
  );
endinterface

interface dae_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] alpha_out;
  logic        alpha_updated;
  logic [31:0] reduced_cwnd;
  logic [31:0] slow_start_threshold;

  modport source (
    output valid, alpha_out, alpha_updated, reduced_cwnd, slow_start_threshold,
    input  ready
  );
  modport sink (
    input  valid, alpha_out, alpha_updated, reduced_cwnd, slow_start_threshold,
    output ready
  );
endinterface

interface dae_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dae_pkg::CFG_IDX_W-1:0]   index;
  logic [dae_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dae_ctrl.sv =====
module dae_ctrl #(
  parameter int FRAC_BITS = dae_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dae_pkg::dae_cmd_t cmd,
  input  dae_pkg::dae_sts_t sts
);
  import dae_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTES,
    S_ACCUM,
    S_DIV_INIT,
    S_DIV,
    S_P1,
    S_P2,
    S_ALPHA,
    S_RED,
    S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.mul_op = MUL_BYTES;
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_BYTES: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_BYTES;
      end
      S_ACCUM:    cmd.accum = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_P1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_P1;
      end
      S_P2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_op    = MUL_P2;
        cmd.prod_save = 1'b1;
      end
      S_ALPHA:    cmd.alpha_wr = 1'b1;
      S_RED: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RED;
      end
      S_DONE:     cmd.result_wr = !out_valid || out_ready;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // hold the result until taken, refill on a new result
      if (cmd.result_wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:     if (in_valid) state <= S_BYTES;
        S_BYTES:    state <= S_ACCUM;
        S_ACCUM:    state <= sts.window_done ? S_DIV_INIT : S_RED;
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + CW'(1);
          if (cnt == LAST_STEP) state <= S_P1;
        end
        S_P1:       state <= S_P2;
        S_P2:       state <= S_ALPHA;
        S_ALPHA:    state <= S_RED;
        S_RED:      state <= S_DONE;
        S_DONE:     if (cmd.result_wr) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/dae_datapath.sv =====
module dae_datapath #(
  parameter int FRAC_BITS = dae_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dae_pkg::dae_cmd_t               cmd,
  output dae_pkg::dae_sts_t               sts,
  input  logic                            cfg_valid,
  input  logic [dae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dae_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [15:0]                     segments_acked,
  input  logic                            ece_flag,
  input  logic [31:0]                     high_tx_mark,
  input  logic [31:0]                     ack_number,
  input  logic [31:0]                     current_cwnd,
  input  logic [31:0]                     bytes_in_flight,
  output logic [16:0]                     alpha_out,
  output logic                            alpha_updated,
  output logic [31:0]                     reduced_cwnd,
  output logic [31:0]                     slow_start_threshold
);
  import dae_pkg::*;

  localparam int GW = FRAC_BITS + 1;                          // Q1.FRAC values
  localparam int MB = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
  localparam int PW = 32 + MB;                                // product width
  localparam int SW = 2 * FRAC_BITS + 2;                      // alpha blend sum
  localparam logic [GW-1:0]          ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0]   TWO = {1'b1, {(FRAC_BITS + 1){1'b0}}};

  // configuration
  logic [16:0] gain;
  logic [15:0] seg_size;

  // captured item
  logic [15:0] segs;
  logic        ece;
  logic [31:0] htx;
  logic [31:0] ackn;
  logic [31:0] cwnd;
  logic [31:0] infl;

  // estimator state
  logic [31:0]   acked;
  logic [31:0]   marked;
  logic [31:0]   window_end;
  logic [GW-1:0] alpha;
  logic          upd;

  // work registers
  logic [PW-1:0] prod;
  logic [PW-1:0] acc;
  logic [31:0]   rem;
  logic [GW-1:0] quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= GAIN_RESET;
      seg_size <= SEG_SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_GAIN) begin
        gain <= cfg_data;
      end else if (cfg_index == REG_SEGMENT_SIZE) begin
        seg_size <= cfg_data[15:0];
      end
    end
  end

  // gain clipped to one and rescaled to FRAC_BITS
  logic [16:0]   g_clip;
  logic [GW-1:0] g_s;
  logic [16:0]   alpha_q16;
  assign g_clip = (gain > GAIN_FULL) ? GAIN_FULL : gain;

  if (FRAC_BITS >= 16) begin : g_wide
    assign g_s       = GW'(g_clip) << (FRAC_BITS - 16);
    assign alpha_q16 = 17'(alpha >> (FRAC_BITS - 16));
  end else begin : g_narrow
    assign g_s       = GW'(g_clip >> (16 - FRAC_BITS));
    assign alpha_q16 = 17'(alpha) << (16 - FRAC_BITS);
  end

  // window end: serial compare modulo 2^32
  logic [31:0] ack_diff;
  assign ack_diff        = ackn - window_end;
  assign sts.window_done = !ack_diff[31];

  // saturating counters
  logic [32:0] acked_sum;
  logic [32:0] marked_sum;
  assign acked_sum  = {1'b0, acked}  + {1'b0, prod[31:0]};
  assign marked_sum = {1'b0, marked} + {1'b0, prod[31:0]};

  // one restoring division step
  logic [32:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, acked});

  // fraction, clamped; zero when nothing was acked
  logic [GW-1:0] frac;
  assign frac = (acked == '0) ? '0 : ((quo > ONE) ? ONE : quo);

  // shared multiplier
  logic [31:0] mul_a;
  logic [MB-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_BYTES: begin
        mul_a = 32'(seg_size);
        mul_b = MB'(segs);
      end
      MUL_P1: begin
        mul_a = 32'(ONE - g_s);
        mul_b = MB'(alpha);
      end
      MUL_P2: begin
        mul_a = 32'(g_s);
        mul_b = MB'(frac);
      end
      MUL_RED: begin
        mul_a = cwnd;
        mul_b = MB'(TWO - (FRAC_BITS + 2)'(alpha));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // alpha blend
  logic [SW-1:0]        blend;
  logic [FRAC_BITS+1:0] blend_sh;
  logic [GW-1:0]        alpha_new;
  assign blend     = acc[SW-1:0] + prod[SW-1:0];
  assign blend_sh  = blend[SW-1:FRAC_BITS];
  assign alpha_new = (blend_sh > (FRAC_BITS + 2)'(ONE)) ? ONE : blend_sh[GW-1:0];

  // window reduction and threshold
  logic [31:0] red;
  logic [31:0] mss32;
  logic [31:0] mss2;
  logic [31:0] half_infl;
  logic [31:0] rc;
  logic [31:0] ss_a;
  logic [31:0] ss;
  assign red       = prod[FRAC_BITS+32:FRAC_BITS+1];
  assign mss32     = 32'(seg_size);
  assign mss2      = {15'b0, seg_size, 1'b0};
  assign half_infl = {1'b0, infl[31:1]};
  assign rc        = (red > mss32) ? red : mss32;
  assign ss_a      = (red > half_infl) ? red : half_infl;
  assign ss        = (ss_a < mss2) ? mss2 : ss_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      acked      <= '0;
      marked     <= '0;
      window_end <= '0;
      alpha      <= ONE;
    end else begin
      if (cmd.accum) begin
        acked <= acked_sum[32] ? '1 : acked_sum[31:0];
        if (ece) marked <= marked_sum[32] ? '1 : marked_sum[31:0];
        if (sts.window_done) window_end <= htx;
      end
      if (cmd.alpha_wr) begin
        alpha  <= alpha_new;
        acked  <= '0;
        marked <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      segs <= segments_acked;
      ece  <= ece_flag;
      htx  <= high_tx_mark;
      ackn <= ack_number;
      cwnd <= current_cwnd;
      infl <= bytes_in_flight;
    end
    if (cmd.accum) upd <= sts.window_done;
    if (cmd.mul_en) prod <= PW'(mul_a) * PW'(mul_b);
    if (cmd.prod_save) acc <= prod;
    if (cmd.div_init) begin
      // integer part of marked/acked is 0 or 1
      if (marked >= acked) begin
        quo <= GW'(1);
        rem <= marked - acked;
      end else begin
        quo <= '0;
        rem <= marked;
      end
    end
    if (cmd.div_step) begin
      quo <= {quo[GW-2:0], q_bit};
      rem <= q_bit ? 32'(rem_sh - {1'b0, acked}) : rem_sh[31:0];
    end
    if (cmd.result_wr) begin
      alpha_out            <= alpha_q16;
      alpha_updated        <= upd;
      reduced_cwnd         <= rc;
      slow_start_threshold <= ss;
    end
  end

endmodule

// ===== rtl/dctcp_alpha_estimator.sv =====
// DCTCP congestion estimator. Each ACK item adds segments_acked * segment_size
// to an acked-byte count (and to a marked-byte count when ece_flag is set),
// both saturating at 2^32-1. When ack_number reaches the stored window end
// (serial compare modulo 2^32) the block stores high_tx_mark as the next window
// end, computes the marked fraction, blends it into alpha with the gain
// register as EWMA weight, and clears both counts. Every item yields one result
// item: alpha in Q1.16, a flag telling whether alpha was recomputed, the reduced
// window max((1-alpha/2)*cwnd, mss) and the slow-start threshold
// max((1-alpha/2)*cwnd, inflight/2, 2*mss). One item is worked on at a time.
// An item goes through the byte-count multiply, the accumulate and the window
// reduction; one that ends a window also goes through the bit-serial fraction
// divider (one quotient bit per cycle) and the two blend terms. The single shared
// multiplier serves the byte count, the blend terms and the window reduction. A
// finished result sits in an output register, so the block takes the next item
// while that result waits to be taken, but holds the new item's result until the
// earlier one is taken. Configuration writes are always ready; write them only
// while the block is idle. Unknown register indexes are ignored.
module dctcp_alpha_estimator #(
  parameter int FRAC_BITS = dae_pkg::FRAC_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  dae_in_if.sink       ack_in,
  dae_out_if.source    result_out,
  dae_cfg_if.sink      cfg
);
  import dae_pkg::*;

  dae_cmd_t cmd;
  dae_sts_t sts;

  // configuration registers take every write
  assign cfg.ready = 1'b1;

  // sequencer: steps the datapath through accumulate, divide, blend, reduce
  dae_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ack_in.valid),
    .in_ready  (ack_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: counters, alpha state, divider, shared multiplier, result register
  dae_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_valid            (cfg.valid),
    .cfg_index            (cfg.index),
    .cfg_data             (cfg.data),
    .segments_acked       (ack_in.segments_acked),
    .ece_flag             (ack_in.ece_flag),
    .high_tx_mark         (ack_in.high_tx_mark),
    .ack_number           (ack_in.ack_number),
    .current_cwnd         (ack_in.current_cwnd),
    .bytes_in_flight      (ack_in.bytes_in_flight),
    .alpha_out            (result_out.alpha_out),
    .alpha_updated        (result_out.alpha_updated),
    .reduced_cwnd         (result_out.reduced_cwnd),
    .slow_start_threshold (result_out.slow_start_threshold)
  );

endmodule

// ===== tb/dae_checker.sv =====
module dae_checker (
  input  logic clk,
  input  logic rst,
  dae_in_if    ack_in,
  dae_out_if   result_out,
  dae_cfg_if   cfg,
  output int   fails,
  output int   pending,
  output int   results,
  output int   windows
);
  import dae_pkg::*;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  typedef struct packed {
    logic [16:0] alpha;
    logic        updated;
    logic [31:0] reduced;
    logic [31:0] ssthresh;
  } dctcp_result_t;

  dctcp_result_t pending_results[$];

  // Shadow of the block's registers and estimator state
  logic [16:0] gain_r;
  logic [15:0] mss_r;
  logic [31:0] acked_r;
  logic [31:0] marked_r;
  logic [31:0] win_end_r;
  logic [16:0] alpha_r;

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Advance the estimator by one ACK item and return the result it yields
  function automatic dctcp_result_t dctcp_update(
    input logic [15:0] segs,
    input logic        ece,
    input logic [31:0] htx,
    input logic [31:0] ackn,
    input logic [31:0] cwnd,
    input logic [31:0] infl
  );
    logic [31:0]   bytes;
    logic [31:0]   seq_gap;
    logic [16:0]   g;
    logic [47:0]   frac_w;
    logic [16:0]   frac;
    logic [63:0]   blend;
    logic [63:0]   red;
    logic [31:0]   ss;
    logic [31:0]   two_mss;
    dctcp_result_t r;
    bytes = 32'(segs) * 32'(mss_r);
    acked_r = add_sat(acked_r, bytes);
    if (ece) marked_r = add_sat(marked_r, bytes);
    r.updated = 1'b0;
    seq_gap = ackn - win_end_r;
    if (!seq_gap[31]) begin
      g = (gain_r > GAIN_FULL) ? GAIN_FULL : gain_r;
      win_end_r = htx;
      frac = '0;
      if (acked_r != 0) begin
        frac_w = {marked_r, 16'b0} / 48'(acked_r);
        frac = (frac_w > 48'(ALPHA_ONE)) ? ALPHA_ONE : frac_w[16:0];
      end
      blend = (64'(ALPHA_ONE - g) * 64'(alpha_r) + 64'(g) * 64'(frac)) >> 16;
      alpha_r = (blend > 64'(ALPHA_ONE)) ? ALPHA_ONE : blend[16:0];
      acked_r = '0;
      marked_r = '0;
      r.updated = 1'b1;
    end
    red = (64'(cwnd) * (64'(ALPHA_ONE) * 2 - 64'(alpha_r))) >> 17;
    two_mss = 32'(mss_r) * 2;
    r.alpha = alpha_r;
    r.reduced = (red > 64'(mss_r)) ? red[31:0] : 32'(mss_r);
    ss = (red[31:0] > (infl >> 1)) ? red[31:0] : (infl >> 1);
    r.ssthresh = (ss < two_mss) ? two_mss : ss;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    dctcp_result_t want;
    if (rst) begin
      gain_r    = GAIN_RESET;
      mss_r     = SEG_SIZE_RESET;
      acked_r   = '0;
      marked_r  = '0;
      win_end_r = '0;
      alpha_r   = ALPHA_ONE;
      pending_results.delete();
      pending   = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_GAIN:         gain_r = cfg.data;
          REG_SEGMENT_SIZE: mss_r  = cfg.data[15:0];
          default: ;
        endcase
      end
      // Results first: a result never belongs to an item taken on the same edge
      if (result_out.valid && result_out.ready) begin
        if (pending_results.size() == 0) begin
          fails++;
          $error("result item with no prediction waiting");
        end else begin
          want = pending_results.pop_front();
          results++;
          if (want.updated) windows++;
          if (result_out.alpha_out !== want.alpha) begin
            fails++;
            $error("alpha_out: expected %0d, got %0d", want.alpha, result_out.alpha_out);
          end
          if (result_out.alpha_updated !== want.updated) begin
            fails++;
            $error("alpha_updated: expected %0d, got %0d", want.updated,
                   result_out.alpha_updated);
          end
          if (result_out.reduced_cwnd !== want.reduced) begin
            fails++;
            $error("reduced_cwnd: expected %0d, got %0d", want.reduced,
                   result_out.reduced_cwnd);
          end
          if (result_out.slow_start_threshold !== want.ssthresh) begin
            fails++;
            $error("slow_start_threshold: expected %0d, got %0d", want.ssthresh,
                   result_out.slow_start_threshold);
          end
        end
      end
      if (ack_in.valid && ack_in.ready)
        pending_results.push_back(dctcp_update(ack_in.segments_acked, ack_in.ece_flag,
                                               ack_in.high_tx_mark, ack_in.ack_number,
                                               ack_in.current_cwnd,
                                               ack_in.bytes_in_flight));
      pending = pending_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import dae_pkg::*;

  // Indexes past the two real registers; writes there must leave the block alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  // Hold after the last result for longer than the longest item takes
  localparam int DRAIN_HOLD      = 32;
  // Cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 242;

  logic clk = 1'b0;
  logic rst;

  dae_in_if  ack_in ();
  dae_out_if result_out ();
  dae_cfg_if cfg ();

  int fails;
  int pending;
  int results;
  int windows;

  // Stimulus bookkeeping
  int          src_idle_pct;
  int          snk_idle_pct;
  int          mark_pct;
  int          items_sent;
  int          settings;
  int          idle_cycles;
  logic [15:0] cur_mss;
  // Sender's view of the connection: oldest unacked byte and highest byte sent
  logic [31:0] una;
  logic [31:0] smax;

  always #4 clk = ~clk;

  dctcp_alpha_estimator dut (
    .clk        (clk),
    .rst        (rst),
    .ack_in     (ack_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  dae_checker chk (
    .clk        (clk),
    .rst        (rst),
    .ack_in     (ack_in),
    .result_out (result_out),
    .cfg        (cfg),
    .fails      (fails),
    .pending    (pending),
    .results    (results),
    .windows    (windows)
  );

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (ack_in.valid && ack_in.ready) || (result_out.valid && result_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: drop ready in random bursts, at the rate of the phase
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result_out.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_out.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < snk_idle_pct) begin
        result_out.ready = 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        result_out.ready = 1'b1;
      end
    end
  end

  // Present one ACK item and hold it until the block takes it; return at a
  // falling edge so back-to-back items keep valid high without a glitch
  task automatic send_ack(
    input logic [15:0] segs,
    input logic        ece,
    input logic [31:0] htx,
    input logic [31:0] ackn,
    input logic [31:0] cwnd,
    input logic [31:0] infl
  );
    int gap;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      ack_in.valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    ack_in.segments_acked  = segs;
    ack_in.ece_flag        = ece;
    ack_in.high_tx_mark    = htx;
    ack_in.ack_number      = ackn;
    ack_in.current_cwnd    = cwnd;
    ack_in.bytes_in_flight = infl;
    ack_in.valid           = 1'b1;
    do @(posedge clk); while (!ack_in.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg.index = idx;
    cfg.data  = val;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
    if (idx == REG_SEGMENT_SIZE) cur_mss = val[15:0];
  endtask

  // Hold the sender until every predicted result is back, then let the block go idle
  task automatic settle_block();
    ack_in.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_HOLD) @(negedge clk);
  endtask

  // Reprogram both registers from idle, and poke the unused indexes as well
  task automatic set_regs(input logic [16:0] gain, input logic [15:0] mss);
    settle_block();
    write_reg(REG_GAIN, gain);
    write_reg(REG_SEGMENT_SIZE, 17'(mss));
    write_reg(REG_SPARE_A, 17'($urandom));
    write_reg(REG_SPARE_B, 17'($urandom));
    settings++;
  endtask

  // Mostly a well-formed flow: the ACK advances by the bytes it covers and the
  // window end tracks what was sent. About one item in ten is noise.
  task automatic random_ack();
    logic [15:0] segs;
    logic        ece;
    logic [31:0] htx;
    logic [31:0] ackn;
    logic [31:0] cwnd;
    logic [31:0] infl;
    int          pick;
    pick = $urandom_range(0, 99);
    ece  = $urandom_range(0, 99) < mark_pct;
    cwnd = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 1 << 20));
    if (pick < 10) begin
      segs = 16'($urandom);
      ackn = $urandom;
      htx  = ($urandom_range(0, 3) == 0) ? 32'($urandom) : smax + $urandom_range(0, 4096);
      infl = $urandom;
    end else begin
      segs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
      // duplicate ACK: nothing new covered
      if (pick < 15) segs = '0;
      una = una + 32'(segs) * 32'(cur_mss);
      if ((smax - una) & 32'h8000_0000) smax = una;
      smax = smax + 32'($urandom_range(0, 8)) * 32'(cur_mss);
      ackn = una;
      htx  = smax;
      infl = ($urandom_range(0, 4) == 0) ? 32'($urandom) : smax - una;
    end
    send_ack(segs, ece, htx, ackn, cwnd, infl);
  endtask

  initial begin : stimulus
    logic [16:0] gain_tab [RANDOM_PHASES];
    logic [15:0] mss_tab  [RANDOM_PHASES];
    ack_in.valid           = 1'b0;
    ack_in.segments_acked  = '0;
    ack_in.ece_flag        = 1'b0;
    ack_in.high_tx_mark    = '0;
    ack_in.ack_number      = '0;
    ack_in.current_cwnd    = '0;
    ack_in.bytes_in_flight = '0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_GAIN;
    cfg.data     = '0;
    src_idle_pct = 20;
    snk_idle_pct = 20;
    mark_pct     = 50;
    items_sent   = 0;
    settings     = 1;
    cur_mss      = SEG_SIZE_RESET;
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed part at reset values: gain 1/16, 536-byte segments, alpha 1.0.
    // All-zero item: window ends with nothing acked, so the fraction is zero.
    send_ack('0, 1'b0, '0, '0, '0, '0);
    // All-ones item: ACK sits just behind the window end, counters only grow
    send_ack('1, 1'b1, '1, '1, '1, '1);
    // Farthest ACK that still counts as reaching the window end
    send_ack(16'd10, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100000, '0);
    // Exactly half the sequence space behind: not reached; inflight/2 dominates
    send_ack(16'd1, 1'b1, 32'h8000_1000, 32'h0000_0000, 32'd1000, '1);
    // ACK equal to the window end; tiny window so the segment floors win
    send_ack(16'd4, 1'b1, 32'h9000_0000, 32'h8000_0000, 32'd10, '0);
    send_ack(16'd2, 1'b0, 32'h9000_0000, 32'h9000_0000, '1, '0);

    // Gain of one and largest segment: drive both counters into saturation
    set_regs(GAIN_FULL, 16'hFFFF);
    send_ack('1, 1'b1, 32'hA000_0000, 32'h8000_3000, 32'd77777, 32'd3);
    send_ack('1, 1'b1, 32'hA000_0000, 32'h8000_4000, 32'd77777, 32'd3);
    send_ack('0, 1'b0, 32'hA000_0000, 32'h9000_0000, '1, 32'd5);
    // Unmarked window with full gain takes alpha to zero: no reduction at all
    send_ack(16'd1, 1'b0, 32'hB000_0000, 32'hA000_0000, '1, '0);

    // Zero gain: alpha frozen; one-byte segments
    set_regs(17'd0, 16'd1);
    send_ack(16'd3, 1'b1, 32'hC000_0000, 32'hB000_0000, 32'd12345, 32'd7);
    send_ack('0, 1'b0, 32'hC000_0000, 32'hB000_0000, '0, 32'd1);

    // Gain above one must act as exactly one
    set_regs('1, 16'd1460);
    send_ack(16'd5, 1'b1, 32'hD000_0000, 32'hC000_0000, 32'd4096, '0);

    // Zero segment size: no bytes counted and both floors collapse to zero
    set_regs(GAIN_FULL + 17'd1, 16'd0);
    send_ack(16'd9, 1'b1, 32'hE000_0000, 32'hD000_0000, 32'd4096, '0);
    send_ack(16'd9, 1'b0, 32'hE000_0000, 32'hD000_0000, '0, '0);

    // Random part: one register setting per phase, each with its own marking
    // rate and idling mix; the last phase runs with no idling on either side
    gain_tab = '{GAIN_RESET, GAIN_FULL, 17'd0, 17'h1FFFF, 17'd1, 17'd32768,
                 17'($urandom_range(0, 131071)), 17'($urandom_range(0, 65536))};
    mss_tab  = '{SEG_SIZE_RESET, 16'hFFFF, 16'd1, 16'd0, 16'd1460,
                 16'($urandom_range(0, 65535)), 16'd9000, 16'($urandom_range(1, 65535))};
    una  = 32'hE000_0000;
    smax = una;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_regs(gain_tab[p], mss_tab[p]);
      mark_pct     = (p == 0) ? 0 : (p == 1) ? 100 : $urandom_range(0, 100);
      src_idle_pct = (p % 3 == 2 || p == RANDOM_PHASES - 1) ? 0 : 20;
      snk_idle_pct = (p % 3 == 1 || p == RANDOM_PHASES - 1) ? 0 : 20;
      // send one phase's flow across the 2^32 wrap
      if (p == 3) begin
        una  = 32'hFFFF_FFFF - 32'($urandom_range(0, 1 << 16));
        smax = una;
      end
      repeat (ITEMS_PER_PHASE) random_ack();
    end

    settle_block();
    $display("Covered %0d ACK items over %0d register settings; %0d closed a window.",
             items_sent, settings, windows);
    $display("Compared %0d result items field by field, %0d mismatches.", results, fails);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
